@@ hdl/grcq_pkg.sv @@
`timescale 1ns / 1ps
package grcq_pkg;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam int COORD_W = 8;
    localparam int CFG_W   = 9;
    localparam int CNT_W   = 17;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 24;

    localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 9'd256;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_CELL  = 8'b0000_0100,
        S_CHK   = 8'b0000_1000,
        S_URD   = 8'b0001_0000,
        S_UWR   = 8'b0010_0000,
        S_QRUN  = 8'b0100_0000,
        S_QOUT  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic cell_wr;
        logic upd_wr;
        logic q_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic w_skip;
        logic upd_last;
        logic q_done;
        logic out_busy;
    } sts_t;

endpackage

@@ hdl/grid_rectangle_count_query_unit.sv @@
`timescale 1ns / 1ps
// Counts set cells in a rectangle of a square one-bit grid, kept as a 2D Fenwick
// tree of counts in a RAM beside a RAM of the raw cells. After reset the block
// clears all 4^ceil(log2 GRID_SIZE) entries of both RAMs (65536 at the default),
// one entry a cycle, with s_tready low. A write beat ends after the cell check
// when the cell keeps its value or lies outside the grid; otherwise it does one
// read-modify-write of the tree RAM for each of the U tree nodes on the update path
// (at most (log2 GRID_SIZE + 1)^2, 81 at the default). A query beat walks four
// prefix sums, one tree RAM read a cycle, each prefix sum visiting at most 64 nodes
// at the default. One beat is worked on at a
// time; a result may wait in the output register while the next beat is taken.
module grid_rectangle_count_query_unit
    import grcq_pkg::*;
#(
    parameter int GRID_SIZE = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // action, row_lo, col_lo, row_hi, col_hi, cell_value
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // cell_count
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    cmd_t cmd;
    sts_t sts;

    grcq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_query (s_tdata[0] == ACT_QUERY),
        .sts      (sts),
        .cmd      (cmd)
    );

    grcq_dpath #(.GRID_SIZE(GRID_SIZE)) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

@@ hdl/grcq_ram.sv @@
`timescale 1ns / 1ps
module grcq_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/grcq_ctrl.sv @@
`timescale 1ns / 1ps
module grcq_ctrl
    import grcq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic in_query,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    cmd.load   = 1'b1;
                    state_next = in_query ? S_QRUN : S_CELL;
                end
            end
            S_CELL: begin
                state_next = S_CHK;
            end
            S_CHK: begin
                if (sts.w_skip) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.cell_wr = 1'b1;
                    state_next  = S_URD;
                end
            end
            S_URD: begin
                state_next = S_UWR;
            end
            S_UWR: begin
                cmd.upd_wr = 1'b1;
                state_next = sts.upd_last ? S_IDLE : S_URD;
            end
            S_QRUN: begin
                if (sts.q_done) begin
                    state_next = S_QOUT;
                end else begin
                    cmd.q_step = 1'b1;
                end
            end
            S_QOUT: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hdl/grcq_dpath.sv @@
`timescale 1ns / 1ps
module grcq_dpath
    import grcq_pkg::*;
#(
    parameter int GRID_SIZE = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    localparam int AW    = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
    localparam int IW    = AW + 2;
    localparam int DEPTH = 1 << (2 * AW);
    localparam int NW    = $clog2(GRID_SIZE * GRID_SIZE + 1);
    localparam int SW    = (IW > CFG_W) ? IW : CFG_W;
    localparam int EW    = (NW > CNT_W) ? NW : CNT_W;

    logic [CFG_W-1:0]  grid_size_reg, grid_size_next;
    logic [IW-1:0]     a1_reg, a1_next, a0_reg, a0_next;
    logic [IW-1:0]     b1_reg, b1_next, b0_reg, b0_next;
    logic [IW-1:0]     i_reg, i_next, j_reg, j_next;
    logic [2:0]        pfx_reg, pfx_next;
    logic              bit_reg, bit_next, wok_reg, wok_next;
    logic              pend_reg, pend_next, neg_reg, neg_next;
    logic [NW-1:0]     acc_reg, acc_next;
    logic [2*AW-1:0]   clr_reg, clr_next;
    logic              mvalid_reg, mvalid_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              in_act, in_bit;
    logic [SW-1:0]     r0w, c0w, r1w, c1w, side, r1c, c1c, gmax;
    logic              q_empty, w_ok;
    logic [IW-1:0]     a1_in, a0_in, b1_in, b0_in;
    logic [IW-1:0]     i_m1, j_m1, ci_m1, cj_m1, low_i, low_j, ni, nj, ui, uj;
    logic [2*AW-1:0]   addr_ij, addr_cell;
    logic [NW-1:0]     tree_rd, tree_wd;
    logic              cell_rd;
    logic              live;
    logic [2:0]        pfx_inc;
    logic [IW-1:0]     a_of_inc, b_of_inc, b_of_cur;
    logic [EW-1:0]     acc_ext;

    function automatic logic [IW-1:0] lowbit(input logic [IW-1:0] x);
        return x & (~x + IW'(1));
    endfunction

    // item decode
    assign in_act = s_tdata[0];
    assign r0w    = SW'(s_tdata[8:1]);
    assign c0w    = SW'(s_tdata[16:9]);
    assign r1w    = SW'(s_tdata[24:17]);
    assign c1w    = SW'(s_tdata[32:25]);
    assign in_bit = s_tdata[33];
    assign gmax   = SW'(GRID_SIZE);
    assign side   = (SW'(grid_size_reg) < gmax) ? SW'(grid_size_reg) : gmax;
    assign q_empty = (r0w > r1w) || (c0w > c1w) || (side == '0)
                     || (r0w >= side) || (c0w >= side);
    assign r1c    = (r1w < side) ? r1w : side - SW'(1);
    assign c1c    = (c1w < side) ? c1w : side - SW'(1);
    assign w_ok   = (r0w < gmax) && (c0w < gmax);

    always_comb begin
        if (in_act == ACT_QUERY) begin
            a1_in = q_empty ? '0 : IW'(r1c + SW'(1));
            a0_in = q_empty ? '0 : IW'(r0w);
            b1_in = IW'(c1c + SW'(1));
            b0_in = IW'(c0w);
        end else begin
            a1_in = IW'(r0w + SW'(1));
            a0_in = '0;
            b1_in = IW'(c0w + SW'(1));
            b0_in = '0;
        end
    end

    // node addressing
    assign i_m1      = i_reg - IW'(1);
    assign j_m1      = j_reg - IW'(1);
    assign ci_m1     = a1_reg - IW'(1);
    assign cj_m1     = b1_reg - IW'(1);
    assign addr_ij   = {i_m1[AW-1:0], j_m1[AW-1:0]};
    assign addr_cell = {ci_m1[AW-1:0], cj_m1[AW-1:0]};
    assign low_i     = lowbit(i_reg);
    assign low_j     = lowbit(j_reg);
    assign ni        = i_reg - low_i;
    assign nj        = j_reg - low_j;
    assign ui        = i_reg + low_i;
    assign uj        = j_reg + low_j;
    assign tree_wd   = bit_reg ? tree_rd + NW'(1) : tree_rd - NW'(1);
    assign live      = (i_reg != '0) && (j_reg != '0) && (pfx_reg < 3'd4);
    assign pfx_inc   = pfx_reg + 3'd1;

    // prefix corners: (a1,b1,+) (a0,b1,-) (a1,b0,-) (a0,b0,+)
    always_comb begin
        case (pfx_inc)
            3'd1:    a_of_inc = a0_reg;
            3'd2:    a_of_inc = a1_reg;
            3'd3:    a_of_inc = a0_reg;
            default: a_of_inc = '0;
        endcase
        case (pfx_inc)
            3'd1:    b_of_inc = b1_reg;
            3'd2:    b_of_inc = b0_reg;
            3'd3:    b_of_inc = b0_reg;
            default: b_of_inc = '0;
        endcase
        case (pfx_reg)
            3'd0:    b_of_cur = b1_reg;
            3'd1:    b_of_cur = b1_reg;
            default: b_of_cur = b0_reg;
        endcase
    end

    assign acc_ext = EW'(acc_reg);

    always_comb begin
        grid_size_next = cfg_wr_en ? cfg_wr_data : grid_size_reg;
        a1_next  = a1_reg;
        a0_next  = a0_reg;
        b1_next  = b1_reg;
        b0_next  = b0_reg;
        i_next   = i_reg;
        j_next   = j_reg;
        pfx_next = pfx_reg;
        bit_next = bit_reg;
        wok_next = wok_reg;
        acc_next = acc_reg;
        clr_next = clr_reg;
        cnt_next = cnt_reg;
        pend_next = cmd.q_step && live;
        neg_next  = (pfx_reg == 3'd1) || (pfx_reg == 3'd2);
        mvalid_next = mvalid_reg && !m_tready;

        if (pend_reg) begin
            acc_next = neg_reg ? acc_reg - tree_rd : acc_reg + tree_rd;
        end
        if (cmd.clr_step) begin
            clr_next = clr_reg + (2*AW)'(1);
        end
        if (cmd.load) begin
            a1_next  = a1_in;
            a0_next  = a0_in;
            b1_next  = b1_in;
            b0_next  = b0_in;
            i_next   = a1_in;
            j_next   = b1_in;
            pfx_next = '0;
            bit_next = in_bit;
            wok_next = w_ok;
            acc_next = '0;
        end
        if (cmd.upd_wr) begin
            if (uj > IW'(GRID_SIZE)) begin
                j_next = b1_reg;
                i_next = ui;
            end else begin
                j_next = uj;
            end
        end
        if (cmd.q_step) begin
            if (live && nj != '0) begin
                j_next = nj;
            end else if (live && ni != '0) begin
                i_next = ni;
                j_next = b_of_cur;
            end else begin
                pfx_next = pfx_inc;
                i_next   = a_of_inc;
                j_next   = b_of_inc;
            end
        end
        if (cmd.out_load) begin
            cnt_next    = acc_ext[CNT_W-1:0];
            mvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg <= GRID_SIZE_RESET;
            pfx_reg       <= 3'd4;
            pend_reg      <= 1'b0;
            clr_reg       <= '0;
            mvalid_reg    <= 1'b0;
        end else begin
            grid_size_reg <= grid_size_next;
            pfx_reg       <= pfx_next;
            pend_reg      <= pend_next;
            clr_reg       <= clr_next;
            mvalid_reg    <= mvalid_next;
        end
        a1_reg  <= a1_next;
        a0_reg  <= a0_next;
        b1_reg  <= b1_next;
        b0_reg  <= b0_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        bit_reg <= bit_next;
        wok_reg <= wok_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
    end

    grcq_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_tree_ram (
        .aclk  (aclk),
        .we    (cmd.clr_step || cmd.upd_wr),
        .waddr (cmd.clr_step ? clr_reg : addr_ij),
        .wdata (cmd.clr_step ? '0 : tree_wd),
        .raddr (addr_ij),
        .rdata (tree_rd)
    );

    grcq_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_cell_ram (
        .aclk  (aclk),
        .we    (cmd.clr_step || cmd.cell_wr),
        .waddr (cmd.clr_step ? clr_reg : addr_cell),
        .wdata (cmd.clr_step ? 1'b0 : bit_reg),
        .raddr (addr_cell),
        .rdata (cell_rd)
    );

    assign sts.clr_last = &clr_reg;
    assign sts.w_skip   = !wok_reg || (cell_rd == bit_reg);
    assign sts.upd_last = (uj > IW'(GRID_SIZE)) && (ui > IW'(GRID_SIZE));
    assign sts.q_done   = (pfx_reg == 3'd4);
    assign sts.out_busy = mvalid_reg && !m_tready;

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {{(OUT_W-CNT_W){1'b0}}, cnt_reg};

endmodule

@@ hdl/grcq_checker.sv @@
`timescale 1ns / 1ps
module grcq_checker
    import grcq_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input taken right after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on consecutive cycles");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_W-1:CNT_W] == '0)
        else $error("result padding not zero");

endmodule

bind grid_rectangle_count_query_unit grcq_checker u_grcq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
